[rtl/ntrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ntrs_pkg;

	// ring geometry and field widths
	localparam int DEPTH  = 1024;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int TIME_W = 64;
	localparam int OUT_W  = 10;

	// command codes
	localparam logic CMD_STORE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// status codes
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_EMPTY = 1'b1;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [TIME_W-1:0] time_t;

	// write pointer and wrap flag of the ring
	typedef struct packed {
		logic  wrapped;
		slot_t write_slot;
	} ring_ptr_t;

	// outcome of one search
	typedef struct packed {
		slot_t slot;
		logic  empty;
	} srch_res_t;

	// logical position (oldest first) to physical slot
	function automatic slot_t phys_slot(ring_ptr_t p, slot_t i);
		logic [SLOT_W:0] sum;
		sum = {1'b0, p.write_slot} + {1'b0, i};
		if (sum >= (SLOT_W+1)'(DEPTH)) begin
			sum = sum - (SLOT_W+1)'(DEPTH);
		end
		return p.wrapped ? sum[SLOT_W-1:0] : i;
	endfunction

	function automatic time_t abs_diff(time_t a, time_t b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// low bits of a slot as carried on the result port
	function automatic logic [OUT_W-1:0] out_slot(slot_t s);
		logic [SLOT_W+OUT_W-1:0] ext;
		ext = {{OUT_W{1'b0}}, s};
		return ext[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/ntrs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ntrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/ntrs_search.sv]
`timescale 1ns / 1ps
`default_nettype none

module ntrs_search (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire ntrs_pkg::time_t     query,
	input  wire ntrs_pkg::ring_ptr_t ptr,
	output logic                     busy,
	output logic                     done,
	output ntrs_pkg::srch_res_t      res,
	output logic                     rd_en,
	output ntrs_pkg::slot_t          rd_addr,
	input  wire ntrs_pkg::time_t     rd_data
);

	import ntrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MID,
		ST_PAIR_A,
		ST_PAIR_B,
		ST_PICK
	} state_t;

	state_t    state_q;
	logic      done_q;
	srch_res_t res_q;

	// search context
	ring_ptr_t ptr_q;
	time_t     t_q;
	slot_t     lo_q;
	slot_t     hi_q;
	slot_t     mid_q;
	slot_t     pm_q;
	slot_t     pa_q;
	time_t     da_q;
	time_t     db_q;

	logic [SLOT_W:0] size;
	logic [SLOT_W:0] mid_ext;
	slot_t           mid;
	slot_t           lo_phys;
	slot_t           hi_phys;
	slot_t           mid_phys;
	logic            pair;

	// range size and midpoint of the current step
	always_comb begin
		size     = {1'b0, hi_q} - {1'b0, lo_q} + (SLOT_W+1)'(1);
		mid_ext  = {1'b0, lo_q} + (size >> 1);
		mid      = mid_ext[SLOT_W-1:0];
		lo_phys  = phys_slot(ptr_q, lo_q);
		hi_phys  = phys_slot(ptr_q, hi_q);
		mid_phys = phys_slot(ptr_q, mid);
		pair     = (size == (SLOT_W+1)'(2));
	end

	// memory read request
	always_comb begin
		rd_en   = (state_q == ST_STEP) || (state_q == ST_PAIR_A);
		rd_addr = hi_phys;
		if (state_q == ST_STEP) begin
			rd_addr = pair ? lo_phys : mid_phys;
		end
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (!ptr.wrapped && ptr.write_slot == '0) begin
							res_q   <= '{slot: '0, empty: STAT_EMPTY};
							done_q  <= 1'b1;
						end else if (!ptr.wrapped && ptr.write_slot == SLOT_W'(1)) begin
							res_q   <= '{slot: '0, empty: STAT_OK};
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					state_q <= pair ? ST_PAIR_A : ST_MID;
				end
				ST_MID: begin
					if (rd_data == t_q) begin
						res_q   <= '{slot: pm_q, empty: STAT_OK};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_PAIR_A: begin
					state_q <= ST_PAIR_B;
				end
				ST_PAIR_B: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					res_q   <= '{slot: (da_q <= db_q) ? pa_q : pm_q, empty: STAT_OK};
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ptr_q <= ptr;
				t_q   <= query;
				lo_q  <= '0;
				hi_q  <= ptr.wrapped ? SLOT_W'(DEPTH - 1) : (ptr.write_slot - SLOT_W'(1));
			end
			ST_STEP: begin
				mid_q <= mid;
				pm_q  <= mid_phys;
				pa_q  <= lo_phys;
			end
			ST_MID: begin
				if (rd_data < t_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_PAIR_A: begin
				da_q <= abs_diff(t_q, rd_data);
				pm_q <= hi_phys;
			end
			ST_PAIR_B: begin
				db_q <= abs_diff(t_q, rd_data);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

[rtl/nearest_timestamp_ring_search_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ring store of DEPTH 64-bit timestamps with a nearest-timestamp search. A store beat
// (cmd 0) writes time_value at the write slot, returns that slot and advances the slot,
// wrapping at DEPTH. A search beat (cmd 1) binary-searches the filled entries, oldest
// first, and returns the physical slot nearest time_value (earlier entry on a tie),
// or status 1 with slot 0 when nothing has been stored. Items are taken one at a time.
// A store result is held in the pending result register, then moved to the output
// register; the next beat is accepted only once it has moved. A search of an empty
// store or a single entry passes its result through the sequencer's done register
// and the pending register. Any other search spends a read and a compare state on each
// halving step, as each step waits on the single registered read port of the timestamp
// memory, then reads the final pair in the step and pair states, picks the nearer in
// the pick state and hands the result on through the done and pending registers. At a
// depth of 1024 there are at most ten halving steps. The output register lets the next
// beat be accepted while a finished result still waits; a second result then stalls
// the input until the first is taken. No clearing pass after reset.

module nearest_timestamp_ring_search_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         cmd,
	input  wire logic [ntrs_pkg::TIME_W-1:0]  time_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [ntrs_pkg::OUT_W-1:0]   slot_index,
	output logic                              status
);

	import ntrs_pkg::*;

	ring_ptr_t ptr_q;
	srch_res_t res_q;
	logic      res_pend_q;
	logic      out_valid_q;
	logic [OUT_W-1:0] out_slot_q;
	logic      out_stat_q;

	logic      in_acc;
	logic      do_store;
	logic      do_search;
	logic      out_free;
	logic      eng_busy;
	logic      eng_done;
	srch_res_t eng_res;
	logic      rd_en;
	slot_t     rd_addr;
	time_t     rd_data;

	// input handshake
	assign in_ready  = !eng_busy && !eng_done && !res_pend_q;
	assign in_acc    = in_valid && in_ready;
	assign do_store  = in_acc && (cmd == CMD_STORE);
	assign do_search = in_acc && (cmd == CMD_SEARCH);
	assign out_free  = !out_valid_q || out_ready;

	// timestamp memory
	ntrs_ram #(
		.WIDTH (TIME_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_store),
		.waddr (ptr_q.write_slot),
		.wdata (time_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// search sequencer
	ntrs_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (do_search),
		.query   (time_value),
		.ptr     (ptr_q),
		.busy    (eng_busy),
		.done    (eng_done),
		.res     (eng_res),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// write pointer and wrap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (do_store) begin
			if (ptr_q.write_slot == SLOT_W'(DEPTH - 1)) begin
				ptr_q.write_slot <= '0;
				ptr_q.wrapped    <= 1'b1;
			end else begin
				ptr_q.write_slot <= ptr_q.write_slot + SLOT_W'(1);
			end
		end
	end

	// pending result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_store || eng_done) begin
				res_pend_q <= 1'b1;
			end else if (res_pend_q && out_free) begin
				res_pend_q <= 1'b0;
			end
			if (res_pend_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload and output register
	always_ff @(posedge clk) begin
		if (do_store) begin
			res_q <= '{slot: ptr_q.write_slot, empty: STAT_OK};
		end else if (eng_done) begin
			res_q <= eng_res;
		end
		if (res_pend_q && out_free) begin
			out_slot_q <= out_slot(res_q.slot);
			out_stat_q <= res_q.empty;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_index = out_slot_q;
	assign status     = out_stat_q;

endmodule

`default_nettype wire

[rtl/ntrs_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module ntrs_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        cmd,
	input wire logic [ntrs_pkg::TIME_W-1:0] time_value,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [ntrs_pkg::OUT_W-1:0]  slot_index,
	input wire logic                        status
);

	import ntrs_pkg::*;

	// one beat in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous beat in flight");

	// waiting input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(time_value))
		else $error("input beat changed while waiting");

	// empty search always reports slot zero
	a_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> slot_index == '0)
		else $error("empty status with nonzero slot");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(status))
		else $error("result changed while stalled");

endmodule

bind nearest_timestamp_ring_search_core ntrs_chk u_chk (.*);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import ntrs_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int N_RANDOM    = 1830;
	localparam int STORE_HEAVY = 900;
	localparam int CALM_FROM   = 1550;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [OUT_W-1:0] slot;
		logic             status;
	} result_t;

	// mirror of the timestamp ring and the results it should produce
	class ring_search_scoreboard;
		time_t       stamps [DEPTH];
		int unsigned wr_slot;
		bit          wrapped;
		result_t     slot_results_q[$];
		int unsigned mismatches;

		function new();
			wr_slot = 0;
			wrapped = 1'b0;
			mismatches = 0;
		endfunction

		// oldest-first position to physical slot
		function int unsigned phys_of(int unsigned pos);
			return wrapped ? (wr_slot + pos) % DEPTH : pos;
		endfunction

		// binary search for the slot nearest t, earlier entry wins a tie
		function int unsigned nearest_slot(time_t t, int unsigned count);
			int unsigned lo, hi, size, mid, pa, pb, found;
			time_t       da, db, v;
			bit          done;
			lo = 0;
			hi = count - 1;
			done = 1'b0;
			found = phys_of(0);
			if (count == 1) begin
				done = 1'b1;
			end
			while (!done) begin
				size = hi - lo + 1;
				if (size == 2) begin
					pa = phys_of(lo);
					pb = phys_of(hi);
					da = (t >= stamps[pa]) ? t - stamps[pa] : stamps[pa] - t;
					db = (t >= stamps[pb]) ? t - stamps[pb] : stamps[pb] - t;
					found = (da <= db) ? pa : pb;
					done = 1'b1;
				end else begin
					mid = lo + size / 2;
					v = stamps[phys_of(mid)];
					if (v == t) begin
						found = phys_of(mid);
						done = 1'b1;
					end else if (v < t) begin
						lo = mid;
					end else begin
						hi = mid;
					end
				end
			end
			return found;
		endfunction

		// accepted input beat: update the ring and queue its result
		function void note_beat(logic c, time_t t);
			result_t     r;
			int unsigned count;
			if (c == CMD_STORE) begin
				stamps[wr_slot] = t;
				r.slot = OUT_W'(wr_slot);
				r.status = STAT_OK;
				if (wr_slot == DEPTH - 1) begin
					wr_slot = 0;
					wrapped = 1'b1;
				end else begin
					wr_slot++;
				end
			end else begin
				count = wrapped ? DEPTH : wr_slot;
				if (count == 0) begin
					r.slot = '0;
					r.status = STAT_EMPTY;
				end else begin
					r.slot = OUT_W'(nearest_slot(t, count));
					r.status = STAT_OK;
				end
			end
			slot_results_q = {slot_results_q, r};
		endfunction

		// accepted output beat against the oldest queued result
		function void check_beat(logic [OUT_W-1:0] slot, logic status);
			result_t want;
			if (slot_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result with none queued: slot %0d status %0d", slot, status);
				end
			end else begin
				want = slot_results_q.pop_front();
				if (slot !== want.slot || status !== want.status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected slot %0d status %0d, got slot %0d status %0d",
							want.slot, want.status, slot, status);
					end
				end
			end
		endfunction

		function int pending();
			return slot_results_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [TIME_W-1:0]  time_value;
	logic               out_valid;
	logic               out_ready;
	logic [OUT_W-1:0]   slot_index;
	logic               status;

	ring_search_scoreboard sb;
	bit                    idle_on = 1'b1;
	bit                    hold_req = 1'b0;
	time_t                 rise_stamp;
	time_t                 stored_q[$];
	int unsigned           quiet_cycles = 0;

	nearest_timestamp_ring_search_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.time_value (time_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_index (slot_index),
		.status     (status)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_ready === 1'b1) ||
				(out_valid === 1'b1 && out_ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: check beats, random stalls and the long hold-off
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				sb.check_beat(slot_index, status);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one beat, with an optional idle burst first
	task automatic send_beat(input logic c, input time_t t);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		time_value <= t;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_beat(c, t);
	endtask

	task automatic store_beat(input time_t t);
		stored_q = {stored_q, t};
		if (stored_q.size() > DEPTH) begin
			void'(stored_q.pop_front());
		end
		send_beat(CMD_STORE, t);
	endtask

	// stop offering until every queued result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// mostly rising stores, searches aimed at stored times
	task automatic random_beat(input int store_pct);
		time_t       t;
		time_t       a;
		time_t       b;
		int unsigned i;
		int          sel;
		sel = $urandom_range(0, 99);
		if (sel < store_pct) begin
			if (sel < 3) begin
				// out-of-order store
				t = {$urandom, $urandom};
			end else begin
				case ($urandom_range(0, 19))
					0: ;
					1: rise_stamp += {32'h0, $urandom};
					default: rise_stamp += $urandom_range(1, 2000);
				endcase
				t = rise_stamp;
			end
			store_beat(t);
		end else begin
			i = $urandom_range(0, stored_q.size() - 1);
			a = stored_q[i];
			b = (i + 1 < stored_q.size()) ? stored_q[i + 1] : a;
			case ($urandom_range(0, 9))
				0, 1, 2: t = a;
				3, 4: t = (b >= a) ? a + (b - a) / 2 : a;
				5, 6: t = a + $urandom_range(0, 50) - 25;
				7: t = '0;
				8: t = '1;
				default: t = {$urandom, $urandom};
			endcase
			send_beat(CMD_SEARCH, t);
		end
	endtask

	initial begin
		int k;
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_STORE;
		time_value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, single entry, tie, exact hit, extremes, unordered data
		send_beat(CMD_SEARCH, '0);
		send_beat(CMD_SEARCH, '1);
		store_beat(64'd100);
		send_beat(CMD_SEARCH, '0);
		send_beat(CMD_SEARCH, '1);
		store_beat(64'd200);
		send_beat(CMD_SEARCH, 64'd150);
		send_beat(CMD_SEARCH, 64'd151);
		store_beat(64'd300);
		send_beat(CMD_SEARCH, 64'd200);
		send_beat(CMD_SEARCH, '0);
		store_beat(64'hFFFF_FFFF_FFFF_FFFE);
		send_beat(CMD_SEARCH, '1);
		store_beat(64'h8000_0000_0000_0000);
		send_beat(CMD_SEARCH, 64'd250);
		store_beat('0);
		send_beat(CMD_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF);
		store_beat('1);
		send_beat(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_drained();

		// random part: store-heavy for the first STORE_HEAVY beats, then mixed
		rise_stamp = {32'h0, $urandom};
		for (k = 0; k < N_RANDOM; k++) begin
			if (k == 400) begin
				hold_req = 1'b1;
			end
			if (k == 800 || k == 1200) begin
				wait_drained();
			end
			if (k == CALM_FROM) begin
				idle_on = 1'b0;
			end
			random_beat((k < STORE_HEAVY) ? 90 : 55);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[nearest_timestamp_ring_search_core.f]
rtl/ntrs_pkg.sv
rtl/ntrs_ram.sv
rtl/ntrs_search.sv
rtl/nearest_timestamp_ring_search_core.sv
rtl/ntrs_chk.sv
test/tb.sv
